### rtl/slam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package slam_pkg;
  localparam int SampleBitsDef = 10;
  localparam int DutyBitsDef = 10;
  localparam int PowBits = 31;
  localparam int CfgAddrBits = 3;
  localparam int CfgDataBits = 16;
  localparam logic [CfgAddrBits-1:0] RegIdleLimit = 3'd0;
  localparam logic [CfgAddrBits-1:0] RegNoiseFloor = 3'd1;
  localparam logic [CfgAddrBits-1:0] RegGainScale = 3'd2;
  localparam logic [CfgAddrBits-1:0] RegPeakFloor = 3'd3;
  localparam logic [CfgAddrBits-1:0] RegDecayPeriod = 3'd4;
  localparam logic [13:0] IdleLimitRst = 14'd10000;
  localparam logic [15:0] NoiseFloorRst = 16'd256;
  localparam logic [11:0] GainScaleRst = 12'd1300;
  localparam logic [15:0] PeakFloorRst = 16'd4096;
  localparam logic [10:0] DecayPeriodRst = 11'd1000;
  localparam logic [PowBits-1:0] Max31 = {PowBits{1'b1}};
endpackage
`default_nettype wire

### rtl/slam_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit a cycle
module slam_divider #(
  parameter int NumBits = 48,
  parameter int DenBits = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [NumBits-1:0] num,
  input  wire logic [DenBits-1:0] den,
  output logic                    busy,
  output logic                    done,
  output logic [NumBits-1:0]      quo
);
  localparam int CntBits = $clog2(NumBits + 1);
  logic [NumBits-1:0] shreg;
  logic [DenBits-1:0] rem;
  logic [DenBits-1:0] dreg;
  logic [CntBits-1:0] cnt;
  logic [DenBits:0] trial;

  assign trial = {rem, shreg[NumBits-1]} - {1'b0, dreg};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      shreg <= num;
      rem <= '0;
      dreg <= den;
      cnt <= CntBits'(NumBits);
    end else if (busy) begin
      if (!trial[DenBits]) begin
        rem <= trial[DenBits-1:0];
        shreg <= {shreg[NumBits-2:0], 1'b1};
      end else begin
        rem <= {rem[DenBits-2:0], shreg[NumBits-1]};
        shreg <= {shreg[NumBits-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntBits'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
  assign quo = shreg;
endmodule
`default_nettype wire

### rtl/sound_level_agc_meter.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  signals
// in        request    action, raw_sample; in_valid / in_ready
// out       result     duty_valid, pwm_duty, last_deviation, smoothed_power,
//                      peak_power; out_valid / out_ready
// cfg       write      cfg_we, cfg_index, cfg_data
// A sample runs two serial divisions on the shared divider (/33, /3), each
// a start, 48 quotient bits and done, then a serial squaring. A tick runs
// /17 and the gain/peak division with a serial gain multiply before it, a peak
// decay multiply when the decay period ends, and the triangle /5 once idle.
// Reset is synchronous; the result register holds while out_ready is low,
// and a new request is taken the cycle after the result has been taken.
module sound_level_agc_meter #(
  parameter int SAMPLE_BITS = slam_pkg::SampleBitsDef,
  parameter int DUTY_BITS = slam_pkg::DutyBitsDef
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              action,
  input  wire logic [SAMPLE_BITS-1:0]            raw_sample,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   duty_valid,
  output logic [DUTY_BITS-1:0]                   pwm_duty,
  output logic signed [SAMPLE_BITS:0]            last_deviation,
  output logic [slam_pkg::PowBits-1:0]           smoothed_power,
  output logic [slam_pkg::PowBits-1:0]           peak_power,
  input  wire logic                              cfg_we,
  input  wire logic [slam_pkg::CfgAddrBits-1:0]  cfg_index,
  input  wire logic [slam_pkg::CfgDataBits-1:0]  cfg_data
);
  import slam_pkg::*;

  localparam int DcBits = SAMPLE_BITS + 8;
  localparam int DevBits = SAMPLE_BITS + 1;
  localparam int LpBits = SAMPLE_BITS + 3;
  localparam int SqBits = 2 * LpBits;
  localparam int NB = 48;
  localparam int DB = 32;
  localparam int MulCntBits = 6;
  localparam logic [DUTY_BITS-1:0] DutyMax = {DUTY_BITS{1'b1}};

  typedef enum logic [4:0] {
    S_IDLE, S_DC_DIV, S_DC_WAIT, S_LP_DIV, S_LP_WAIT, S_SQ, S_SUM,
    T_SM_DIV, T_SM_WAIT, T_PK_MUL, T_PK, T_RATIO_MUL, T_RATIO_DIV, T_RATIO_WAIT,
    T_IDLE, T_TRI_DIV, T_TRI_WAIT, S_OUT
  } state_t;

  state_t state;
  logic [13:0] idle_limit;
  logic [15:0] noise_floor;
  logic [11:0] gain_scale;
  logic [15:0] peak_floor;
  logic [10:0] decay_period;

  logic signed [DcBits-1:0] dc_average_x32;
  logic seeded;
  logic signed [DevBits-1:0] deviation;
  logic signed [LpBits-1:0] lowpassed;
  logic [PowBits-1:0] power_sum, power_smooth, power_peak;
  logic [10:0] tick_count;
  logic [13:0] idle_count;
  logic signed [SAMPLE_BITS:0] cur;
  logic [DUTY_BITS-1:0] duty;
  logic [MulCntBits-1:0] mcnt;
  logic [NB-1:0] macc;
  logic [NB-1:0] mcand;
  logic [DB-1:0] mplier;
  logic neg;

  logic div_start, div_busy, div_done;
  logic [NB-1:0] div_num, div_quo;
  logic [DB-1:0] div_den;

  slam_divider #(.NumBits(NB), .DenBits(DB)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .done(div_done), .quo(div_quo)
  );

  logic [PowBits-1:0] floor_v;
  assign floor_v = (peak_floor == 16'd0) ? PowBits'(1) : PowBits'(peak_floor);

  logic signed [SAMPLE_BITS:0] cur_in;
  assign cur_in = raw_sample[SAMPLE_BITS-1]
                ? $signed({1'b1, raw_sample}) : $signed({1'b0, raw_sample});

  logic signed [DcBits+2:0] dc_mag_s;
  logic signed [DcBits+1:0] lp_mag_s;
  logic signed [DcBits-1:0] dc_new;
  logic [PowBits:0] sum_w;
  logic [PowBits:0] sm_in;
  logic [10:0] half;
  logic [10:0] tri_val;
  logic [11:0] tc_inc;
  logic [PowBits-1:0] power;

  assign half = decay_period >> 1;
  assign power = (power_smooth < PowBits'(noise_floor)) ? '0
               : power_smooth - PowBits'(noise_floor);
  assign tc_inc = {1'b0, tick_count} + 12'd1;
  assign tri_val = (tick_count < half) ? tick_count
                 : ((tick_count <= decay_period) ? decay_period - tick_count : 11'd0);
  assign sum_w = {1'b0, power_sum} + {1'b0, macc[PowBits-1:0]};
  assign sm_in = {1'b0, power_smooth} + {1'b0, power_sum};
  // signed DC average from the magnitude quotient
  assign dc_new = neg ? -$signed(DcBits'(div_quo)) : $signed(DcBits'(div_quo));

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    dc_mag_s = '0;
    lp_mag_s = '0;
    unique case (state)
      S_DC_DIV: begin
        dc_mag_s = (DcBits+3)'(dc_average_x32 + DcBits'(cur)) <<< 5;
        div_start = 1'b1;
        div_num = NB'(dc_mag_s < 0 ? -dc_mag_s : dc_mag_s);
        div_den = DB'(33);
      end
      S_LP_DIV: begin
        lp_mag_s = (DcBits+2)'(lowpassed + LpBits'(deviation)) <<< 1;
        div_start = 1'b1;
        div_num = NB'(lp_mag_s < 0 ? -lp_mag_s : lp_mag_s);
        div_den = DB'(3);
      end
      T_SM_DIV: begin
        div_start = 1'b1;
        div_num = NB'(sm_in) << 4;
        div_den = DB'(17);
      end
      T_RATIO_DIV: begin
        div_start = 1'b1;
        div_num = macc;
        div_den = DB'(power_peak);
      end
      T_TRI_DIV: begin
        div_start = 1'b1;
        div_num = NB'(tri_val);
        div_den = DB'(5);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      idle_limit <= IdleLimitRst;
      noise_floor <= NoiseFloorRst;
      gain_scale <= GainScaleRst;
      peak_floor <= PeakFloorRst;
      decay_period <= DecayPeriodRst;
      dc_average_x32 <= '0;
      seeded <= 1'b0;
      deviation <= '0;
      lowpassed <= '0;
      power_sum <= '0;
      power_smooth <= '0;
      power_peak <= PowBits'(PeakFloorRst);
      tick_count <= '0;
      idle_count <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegIdleLimit:   idle_limit <= cfg_data[13:0];
          RegNoiseFloor:  noise_floor <= cfg_data;
          RegGainScale:   gain_scale <= cfg_data[11:0];
          RegPeakFloor:   peak_floor <= cfg_data;
          RegDecayPeriod: decay_period <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          if (action) begin
            state <= T_SM_DIV;
          end else begin
            cur <= cur_in;
            if (!seeded) begin
              dc_average_x32 <= DcBits'(cur_in) <<< 5;
              seeded <= 1'b1;
            end
            state <= S_DC_DIV;
          end
        end
        S_DC_DIV: begin
          neg <= dc_mag_s < 0;
          state <= S_DC_WAIT;
        end
        S_DC_WAIT: if (div_done) begin
          dc_average_x32 <= dc_new;
          deviation <= DevBits'(cur - SAMPLE_BITS'(dc_new / 32));
          state <= S_LP_DIV;
        end
        S_LP_DIV: begin
          neg <= lp_mag_s < 0;
          state <= S_LP_WAIT;
        end
        S_LP_WAIT: if (div_done) begin
          lowpassed <= neg ? -LpBits'(div_quo) : LpBits'(div_quo);
          // |q| = |lp|/4, squared serially
          mcand <= NB'(div_quo[LpBits-1:2]);
          mplier <= DB'(div_quo[LpBits-1:2]);
          macc <= '0;
          mcnt <= MulCntBits'(LpBits);
          state <= S_SQ;
        end
        S_SQ: begin
          if (mplier[0]) macc <= macc + mcand;
          mcand <= mcand << 1;
          mplier <= mplier >> 1;
          mcnt <= mcnt - 1'b1;
          if (mcnt == MulCntBits'(1)) state <= S_SUM;
        end
        S_SUM: begin
          power_sum <= sum_w[PowBits] ? Max31 : sum_w[PowBits-1:0];
          duty <= '0;
          duty_valid <= 1'b0;
          state <= S_OUT;
        end
        T_SM_DIV: state <= T_SM_WAIT;
        T_SM_WAIT: if (div_done) begin
          power_sum <= '0;
          power_smooth <= (div_quo > NB'(Max31)) ? Max31 : div_quo[PowBits-1:0];
          if (tc_inc > {1'b0, decay_period}) begin
            tick_count <= '0;
            mcand <= NB'(power_peak);
            mplier <= DB'(31);
            macc <= '0;
            mcnt <= MulCntBits'(5);
            state <= T_PK_MUL;
          end else begin
            tick_count <= tc_inc[10:0];
            state <= T_PK;
          end
        end
        T_PK_MUL: begin
          if (mplier[0]) macc <= macc + mcand;
          mcand <= mcand << 1;
          mplier <= mplier >> 1;
          mcnt <= mcnt - 1'b1;
          if (mcnt == MulCntBits'(1)) begin
            power_peak <= ((macc + (mplier[0] ? mcand : '0)) >> 5) < NB'(floor_v)
                        ? floor_v : PowBits'((macc + (mplier[0] ? mcand : '0)) >> 5);
            state <= T_PK;
          end
        end
        T_PK: begin
          if (power_smooth > power_peak) power_peak <= power_smooth;
          else if (power_peak == '0) power_peak <= floor_v;
          mcand <= NB'(power);
          mplier <= DB'(gain_scale);
          macc <= '0;
          mcnt <= MulCntBits'(12);
          state <= T_RATIO_MUL;
        end
        T_RATIO_MUL: begin
          if (mplier[0]) macc <= macc + mcand;
          mcand <= mcand << 1;
          mplier <= mplier >> 1;
          mcnt <= mcnt - 1'b1;
          if (mcnt == MulCntBits'(1)) state <= T_RATIO_DIV;
        end
        T_RATIO_DIV: state <= T_RATIO_WAIT;
        T_RATIO_WAIT: if (div_done) begin
          duty <= (div_quo > NB'(DutyMax)) ? DutyMax : div_quo[DUTY_BITS-1:0];
          if (div_quo != '0) idle_count <= '0;
          else if (idle_count < idle_limit) idle_count <= idle_count + 14'd1;
          state <= T_IDLE;
        end
        T_IDLE: state <= (idle_count >= idle_limit) ? T_TRI_DIV : S_OUT;
        T_TRI_DIV: state <= T_TRI_WAIT;
        T_TRI_WAIT: if (div_done) begin
          duty <= (div_quo > NB'(DutyMax)) ? DutyMax : div_quo[DUTY_BITS-1:0];
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == T_SM_DIV) duty_valid <= 1'b1;
    end
  end

  assign pwm_duty = duty;
  assign last_deviation = deviation;
  assign smoothed_power = power_smooth;
  assign peak_power = power_peak;

  property p_no_take_while_full;
    @(posedge clk) disable iff (rst) out_valid |-> !in_ready;
  endproperty
  a_no_take: assert property (p_no_take_while_full) else $error("request taken over result");

  a_peak_nz: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> peak_power != '0) else $error("peak zero");

  a_sample_duty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !duty_valid) |-> pwm_duty == '0) else $error("sample duty");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider started while busy");
endmodule
`default_nettype wire
